[src/jmp_pkg.sv]
// Shared types and constants of the joint matrix palette unit.
`default_nettype none

package jmp_pkg;

    // Item opcodes.
    localparam logic [2:0] OP_START  = 3'd0;
    localparam logic [2:0] OP_TS     = 3'd1;
    localparam logic [2:0] OP_ROT    = 3'd2;
    localparam logic [2:0] OP_IB     = 3'd3;
    localparam logic [2:0] OP_COMMIT = 3'd4;

    localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT32_MIN = -32'sh7FFF_FFFF - 32'sd1;

    // Which product schedule the lanes are running.
    typedef enum logic [1:0] {
        PH_ROT = 2'd0,
        PH_SCL = 2'd1,
        PH_WLD = 2'd2,
        PH_SKN = 2'd3
    } phase_t;

    // Control word that travels with the operands through the lanes.
    typedef struct packed {
        logic       issue;
        logic       first;
        logic       last;
        logic       fin;
        phase_t     phase;
        logic [1:0] col;
        logic [1:0] k;
    } ctrl_t;

    typedef struct packed {
        ctrl_t ctrl;
        logic  sat_any;
    } merge_info_t;

    // Quaternion operands of the nine rotation products:
    // xx yy zz xy xz yz wx wy wz, quaternion order x y z w.
    function automatic logic [1:0] prod_a_sel(input logic [3:0] idx);
        logic [1:0] s;
        case (idx)
            4'd0: s = 2'd0;
            4'd1: s = 2'd1;
            4'd2: s = 2'd2;
            4'd3: s = 2'd0;
            4'd4: s = 2'd0;
            4'd5: s = 2'd1;
            4'd6: s = 2'd3;
            4'd7: s = 2'd3;
            4'd8: s = 2'd3;
            default: s = 2'd0;
        endcase
        return s;
    endfunction

    function automatic logic [1:0] prod_b_sel(input logic [3:0] idx);
        logic [1:0] s;
        case (idx)
            4'd0: s = 2'd0;
            4'd1: s = 2'd1;
            4'd2: s = 2'd2;
            4'd3: s = 2'd1;
            4'd4: s = 2'd2;
            4'd5: s = 2'd2;
            4'd6: s = 2'd0;
            4'd7: s = 2'd1;
            4'd8: s = 2'd2;
            default: s = 2'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

[src/jmp_ram.sv]
// Generic simple dual-port RAM with a registered read.
`default_nettype none

module jmp_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[src/jmp_lane.sv]
// One multiply-accumulate lane: registered product, shifted and summed.
`default_nettype none

module jmp_lane #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire jmp_pkg::ctrl_t              ctrl_in,
    input  wire logic signed [31:0]          a,
    input  wire logic signed [31:0]          b,
    output jmp_pkg::ctrl_t                   ctrl_out,
    output logic signed [66-FRAC_BITS-1:0]   acc
);

    localparam int PW = 64 - FRAC_BITS;
    localparam int AW = PW + 2;

    logic signed [63:0]  prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [PW-1:0] shifted;
    jmp_pkg::ctrl_t      c1_reg;
    jmp_pkg::ctrl_t      c2_reg;
    jmp_pkg::ctrl_t      c2_next;

    // Arithmetic shift of the exact product: truncation toward minus infinity.
    assign shifted = prod_reg[63:FRAC_BITS];

    // The sum leaves the lane only after the last term of a column.
    always_comb begin
        c2_next       = c1_reg;
        c2_next.issue = c1_reg.issue & c1_reg.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg.issue <= 1'b0;
            c2_reg.issue <= 1'b0;
        end else begin
            c1_reg <= ctrl_in;
            c2_reg <= c2_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
        if (c1_reg.issue) begin
            acc_reg <= (c1_reg.first ? '0 : acc_reg) + AW'(shifted);
        end
    end

    assign ctrl_out = c2_reg;
    assign acc      = acc_reg;

endmodule

`default_nettype wire

[src/jmp_merge.sv]
// Merging stage: saturates the lane sums and combines their overflow flags.
`default_nettype none

module jmp_merge #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire jmp_pkg::ctrl_t             ctrl_in [4],
    input  wire logic signed [66-FRAC_BITS-1:0] acc [4],
    output jmp_pkg::merge_info_t            info,
    output logic signed [31:0]              sat_val [4],
    output logic signed [64-FRAC_BITS-1:0]  raw [4]
);

    localparam int PW = 64 - FRAC_BITS;
    localparam int AW = PW + 2;

    logic                 valid_reg;
    jmp_pkg::ctrl_t       ctrl_reg;
    logic                 sat_any_reg;
    logic signed [31:0]   sat_reg [4];
    logic signed [PW-1:0] raw_reg [4];
    logic signed [31:0]   sat_c [4];
    logic [3:0]           ovf_c;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            if (acc[r] > AW'(jmp_pkg::INT32_MAX)) begin
                sat_c[r] = jmp_pkg::INT32_MAX;
                ovf_c[r] = 1'b1;
            end else if (acc[r] < AW'(jmp_pkg::INT32_MIN)) begin
                sat_c[r] = jmp_pkg::INT32_MIN;
                ovf_c[r] = 1'b1;
            end else begin
                sat_c[r] = acc[r][31:0];
                ovf_c[r] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= ctrl_in[0].issue & ctrl_in[1].issue
                       & ctrl_in[2].issue & ctrl_in[3].issue;
        end
    end

    always_ff @(posedge aclk) begin
        ctrl_reg    <= ctrl_in[0];
        sat_any_reg <= |ovf_c;
        for (int r = 0; r < 4; r++) begin
            sat_reg[r] <= sat_c[r];
            raw_reg[r] <= acc[r][PW-1:0];
        end
    end

    always_comb begin
        info.ctrl       = ctrl_reg;
        info.ctrl.issue = valid_reg;
        info.sat_any    = sat_any_reg;
    end

    assign sat_val = sat_reg;
    assign raw     = raw_reg;

endmodule

`default_nettype wire

[src/joint_matrix_palette_unit.sv]
// Top level of the joint matrix palette unit for skeletal skinning.
//
// Items enter on the s_ channel (valid/ready). Opcodes 1 to 3 stage a
// translation and scale, a rotation quaternion or one inverse-bind column;
// opcode 0 restarts joint and skin numbering. A commit (opcode 4) below
// the joint limit builds the local matrix T*R*S, multiplies it by the
// parent's world matrix read from the world RAM (a root multiplies by the
// identity), stores the world matrix, and for a skin joint multiplies it by
// the inverse-bind matrix and sends four column items on the m_ channel.
// Four lanes each own one matrix row and run one 32x32 product per cycle;
// a merging stage saturates the column. Each issue of a product schedule
// passes through fetch, multiply, accumulate and merge. A commit runs
// 3 rotation issues, a state that registers the rotation, 3 scale issues
// and 16 world issues, and then it is back to idle when it has no skin
// output. A skin joint adds 16 skin issues, after which its four columns
// are offered through the four output handshakes.
// s_ready is high only while idle, so one item is in work at a time. The
// results are held stable while the receiver stalls m_ready low. Reset
// returns staging to the identity transform and clears the counters; the
// world RAM is not cleared, a parent is always written before it is read.
`default_nettype none

module joint_matrix_palette_unit #(
    parameter int MAX_JOINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_opcode,
    input  wire logic signed [31:0] s_value_0,
    input  wire logic signed [31:0] s_value_1,
    input  wire logic signed [31:0] s_value_2,
    input  wire logic signed [31:0] s_value_3,
    input  wire logic signed [31:0] s_value_4,
    input  wire logic signed [31:0] s_value_5,
    input  wire logic [1:0]         s_column_select,
    input  wire logic signed [6:0]  s_parent_index,
    input  wire logic               s_is_skin,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [5:0]              m_skin_joint_number,
    output logic [1:0]              m_column_index,
    output logic signed [31:0]      m_elem_0,
    output logic signed [31:0]      m_elem_1,
    output logic signed [31:0]      m_elem_2,
    output logic signed [31:0]      m_elem_3,
    output logic                    m_last_column,
    output logic                    m_parent_error,
    output logic                    m_saturated
);

    localparam int JW   = $clog2(MAX_JOINTS);
    localparam int CW   = $clog2(MAX_JOINTS + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;
    localparam int PW   = 64 - FRAC_BITS;
    localparam int AW   = PW + 2;
    localparam int RW   = PW + 3;
    localparam int DEPTH = 4 * MAX_JOINTS;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_ROT  = 7'b0000010,
        ST_RSUM = 7'b0000100,
        ST_SCL  = 7'b0001000,
        ST_WLD  = 7'b0010000,
        ST_SKN  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0] cnt_reg;
    logic       issuing_reg;
    logic [1:0] out_col_reg;
    logic [CW-1:0] joint_cnt_reg;
    logic [5:0]    skin_cnt_reg;

    // Staged transform.
    logic signed [31:0] trans_reg [3];
    logic signed [31:0] scale_reg [3];
    logic signed [31:0] quat_reg  [4];
    logic signed [31:0] ib_reg    [4][4];

    // Per-commit working data, indexed [column][row].
    logic signed [PW-1:0] qp_reg [9];
    logic signed [31:0]   rot_reg [3][3];
    logic signed [31:0]   loc_reg [3][3];
    logic signed [31:0]   world_reg [4][3];
    logic signed [31:0]   sk_reg [4][4];
    logic [JW-1:0] par_reg;
    logic [JW-1:0] j_reg;
    logic          perr_reg;
    logic          root_reg;
    logic          skin_reg;
    logic          flag_reg;

    jmp_pkg::ctrl_t ctrl_f;
    jmp_pkg::ctrl_t ctrl_q_reg;
    logic           issue_now;
    logic           s_acc;
    logic           m_acc;
    logic           commit_ok;
    logic           perr_c;
    logic           phase_done;

    logic signed [31:0] op_a [4];
    logic signed [31:0] op_b [4];
    jmp_pkg::ctrl_t     lane_ctrl [4];
    logic signed [AW-1:0] lane_acc [4];
    jmp_pkg::merge_info_t minfo;
    logic signed [31:0]   msat [4];
    logic signed [PW-1:0] mraw [4];

    logic [95:0] ram_rdata;
    logic        ram_we;
    logic [JW+1:0] ram_waddr;
    logic [JW+1:0] ram_raddr;

    logic signed [31:0] rot_c [3][3];
    logic [8:0]         rot_ovf;

    assign s_acc = s_valid & s_ready;
    assign m_acc = m_valid & m_ready;
    assign perr_c = ~s_parent_index[6]
                  & (CMPW'(s_parent_index[5:0]) >= CMPW'(joint_cnt_reg));
    assign commit_ok = (s_opcode == jmp_pkg::OP_COMMIT)
                     & (joint_cnt_reg < CW'(MAX_JOINTS));
    assign phase_done = minfo.ctrl.issue & minfo.ctrl.fin;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc && commit_ok) begin
                    state_next = ST_ROT;
                end
            end
            ST_ROT: begin
                if (phase_done) begin
                    state_next = ST_RSUM;
                end
            end
            ST_RSUM: state_next = ST_SCL;
            ST_SCL: begin
                if (phase_done) begin
                    state_next = ST_WLD;
                end
            end
            ST_WLD: begin
                if (phase_done) begin
                    state_next = skin_reg ? ST_SKN : ST_IDLE;
                end
            end
            ST_SKN: begin
                if (phase_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_acc && out_col_reg == 2'd3) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Issue schedule. Rotation and scale issues are single products; the
    // two matrix products walk column by column, four terms per column.
    always_comb begin
        ctrl_f = '0;
        case (state_reg)
            ST_ROT, ST_SCL: begin
                ctrl_f.issue = issuing_reg;
                ctrl_f.phase = (state_reg == ST_ROT) ? jmp_pkg::PH_ROT : jmp_pkg::PH_SCL;
                ctrl_f.col   = cnt_reg[1:0];
                ctrl_f.first = 1'b1;
                ctrl_f.last  = 1'b1;
                ctrl_f.fin   = (cnt_reg == 4'd2);
            end
            ST_WLD, ST_SKN: begin
                ctrl_f.issue = issuing_reg;
                ctrl_f.phase = (state_reg == ST_WLD) ? jmp_pkg::PH_WLD : jmp_pkg::PH_SKN;
                ctrl_f.col   = cnt_reg[3:2];
                ctrl_f.k     = cnt_reg[1:0];
                ctrl_f.first = (cnt_reg[1:0] == 2'd0);
                ctrl_f.last  = (cnt_reg[1:0] == 2'd3);
                ctrl_f.fin   = (cnt_reg == 4'd15);
            end
            default: ctrl_f = '0;
        endcase
    end

    assign issue_now = ctrl_f.issue;
    assign ram_raddr = {par_reg, ctrl_f.k};

    // Control and staged state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            issuing_reg      <= 1'b0;
            out_col_reg      <= '0;
            joint_cnt_reg    <= '0;
            skin_cnt_reg     <= '0;
            ctrl_q_reg.issue <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                trans_reg[i] <= '0;
                scale_reg[i] <= ONE;
            end
            quat_reg[0] <= '0;
            quat_reg[1] <= '0;
            quat_reg[2] <= '0;
            quat_reg[3] <= ONE;
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) begin
                    ib_reg[c][r] <= (c == r) ? ONE : '0;
                end
            end
        end else begin
            state_reg  <= state_next;
            ctrl_q_reg <= ctrl_f;
            if (state_next != state_reg) begin
                issuing_reg <= 1'b1;
                cnt_reg     <= '0;
            end else if (issue_now) begin
                if (ctrl_f.fin) begin
                    issuing_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 4'd1;
            end
            if (m_acc) begin
                out_col_reg <= out_col_reg + 2'd1;
                if (out_col_reg == 2'd3) begin
                    skin_cnt_reg <= skin_cnt_reg + 6'd1;
                end
            end
            if (s_acc) begin
                case (s_opcode)
                    jmp_pkg::OP_START: begin
                        joint_cnt_reg <= '0;
                        skin_cnt_reg  <= '0;
                    end
                    jmp_pkg::OP_TS: begin
                        trans_reg[0] <= s_value_0;
                        trans_reg[1] <= s_value_1;
                        trans_reg[2] <= s_value_2;
                        scale_reg[0] <= s_value_3;
                        scale_reg[1] <= s_value_4;
                        scale_reg[2] <= s_value_5;
                    end
                    jmp_pkg::OP_ROT: begin
                        quat_reg[0] <= s_value_0;
                        quat_reg[1] <= s_value_1;
                        quat_reg[2] <= s_value_2;
                        quat_reg[3] <= s_value_3;
                    end
                    jmp_pkg::OP_IB: begin
                        ib_reg[s_column_select][0] <= s_value_0;
                        ib_reg[s_column_select][1] <= s_value_1;
                        ib_reg[s_column_select][2] <= s_value_2;
                        ib_reg[s_column_select][3] <= s_value_3;
                    end
                    jmp_pkg::OP_COMMIT: begin
                        if (commit_ok) begin
                            joint_cnt_reg <= CW'(joint_cnt_reg + 1'b1);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Rotation elements from the quaternion products, saturated to 32 bits.
    function automatic logic signed [RW-1:0] twice(input logic signed [PW-1:0] p,
                                                   input logic signed [PW-1:0] q,
                                                   input logic sub);
        logic signed [RW-1:0] s;
        s = sub ? (RW'(p) - RW'(q)) : (RW'(p) + RW'(q));
        return s <<< 1;
    endfunction

    function automatic logic [32:0] sat_rw(input logic signed [RW-1:0] x);
        logic [32:0] res;
        if (x > RW'(jmp_pkg::INT32_MAX)) begin
            res = {1'b1, jmp_pkg::INT32_MAX};
        end else if (x < RW'(jmp_pkg::INT32_MIN)) begin
            res = {1'b1, jmp_pkg::INT32_MIN};
        end else begin
            res = {1'b0, x[31:0]};
        end
        return res;
    endfunction

    always_comb begin
        logic signed [RW-1:0] one_w;
        logic signed [RW-1:0] e [9];
        logic [32:0] s;
        one_w = RW'(ONE);
        e[0] = one_w - twice(qp_reg[1], qp_reg[2], 1'b0);
        e[1] = twice(qp_reg[3], qp_reg[8], 1'b0);
        e[2] = twice(qp_reg[4], qp_reg[7], 1'b1);
        e[3] = twice(qp_reg[3], qp_reg[8], 1'b1);
        e[4] = one_w - twice(qp_reg[0], qp_reg[2], 1'b0);
        e[5] = twice(qp_reg[5], qp_reg[6], 1'b0);
        e[6] = twice(qp_reg[4], qp_reg[7], 1'b0);
        e[7] = twice(qp_reg[5], qp_reg[6], 1'b1);
        e[8] = one_w - twice(qp_reg[0], qp_reg[1], 1'b0);
        for (int i = 0; i < 9; i++) begin
            s = sat_rw(e[i]);
            rot_ovf[i] = s[32];
            rot_c[i / 3][i % 3] = s[31:0];
        end
    end

    // Lane operands, selected from the fetch-stage control word. The world
    // RAM data arrives in the same cycle.
    always_comb begin
        logic [3:0] idx;
        logic [1:0] col;
        logic [1:0] k;
        col = ctrl_q_reg.col;
        k   = ctrl_q_reg.k;
        idx = '0;
        for (int r = 0; r < 4; r++) begin
            op_a[r] = '0;
            op_b[r] = '0;
        end
        case (ctrl_q_reg.phase)
            jmp_pkg::PH_ROT: begin
                for (int r = 0; r < 4; r++) begin
                    idx = {col, 2'b00} + 4'(r);
                    if (idx < 4'd9) begin
                        op_a[r] = quat_reg[jmp_pkg::prod_a_sel(idx)];
                        op_b[r] = quat_reg[jmp_pkg::prod_b_sel(idx)];
                    end
                end
            end
            jmp_pkg::PH_SCL: begin
                if (col != 2'd3) begin
                    for (int r = 0; r < 3; r++) begin
                        op_a[r] = rot_reg[col][r];
                        op_b[r] = scale_reg[col];
                    end
                end
            end
            jmp_pkg::PH_WLD: begin
                for (int r = 0; r < 4; r++) begin
                    if (root_reg || r == 3) begin
                        op_a[r] = (k == 2'(r)) ? ONE : '0;
                    end else begin
                        op_a[r] = ram_rdata[32*r +: 32];
                    end
                    if (k == 2'd3) begin
                        op_b[r] = (col == 2'd3) ? ONE : '0;
                    end else if (col == 2'd3) begin
                        op_b[r] = trans_reg[k];
                    end else begin
                        op_b[r] = loc_reg[col][k];
                    end
                end
            end
            jmp_pkg::PH_SKN: begin
                for (int r = 0; r < 4; r++) begin
                    if (r == 3) begin
                        op_a[r] = (k == 2'd3) ? ONE : '0;
                    end else begin
                        op_a[r] = world_reg[k][r];
                    end
                    op_b[r] = ib_reg[col][k];
                end
            end
            default: ;
        endcase
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        jmp_lane #(
            .FRAC_BITS(FRAC_BITS)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl_in (ctrl_q_reg),
            .a       (op_a[g]),
            .b       (op_b[g]),
            .ctrl_out(lane_ctrl[g]),
            .acc     (lane_acc[g])
        );
    end

    jmp_merge #(
        .FRAC_BITS(FRAC_BITS)
    ) u_merge (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctrl_in(lane_ctrl),
        .acc    (lane_acc),
        .info   (minfo),
        .sat_val(msat),
        .raw    (mraw)
    );

    // World matrix rows 0..2, one column per RAM word.
    assign ram_we    = minfo.ctrl.issue & (minfo.ctrl.phase == jmp_pkg::PH_WLD);
    assign ram_waddr = {j_reg, minfo.ctrl.col};

    jmp_ram #(
        .WIDTH(96),
        .DEPTH(DEPTH)
    ) u_world_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata({msat[2], msat[1], msat[0]}),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Working registers of the current commit.
    always_ff @(posedge aclk) begin
        logic [3:0] widx;
        widx = '0;
        if (s_acc && commit_ok) begin
            par_reg  <= JW'(s_parent_index[5:0]);
            j_reg    <= joint_cnt_reg[JW-1:0];
            perr_reg <= perr_c;
            root_reg <= s_parent_index[6] | perr_c;
            skin_reg <= s_is_skin;
            flag_reg <= 1'b0;
        end
        if (state_reg == ST_RSUM) begin
            rot_reg  <= rot_c;
            flag_reg <= flag_reg | (|rot_ovf);
        end
        if (minfo.ctrl.issue) begin
            case (minfo.ctrl.phase)
                jmp_pkg::PH_ROT: begin
                    for (int r = 0; r < 4; r++) begin
                        widx = {minfo.ctrl.col, 2'b00} + 4'(r);
                        if (widx < 4'd9) begin
                            qp_reg[widx] <= mraw[r];
                        end
                    end
                end
                jmp_pkg::PH_SCL: begin
                    if (minfo.ctrl.col != 2'd3) begin
                        for (int r = 0; r < 3; r++) begin
                            loc_reg[minfo.ctrl.col][r] <= msat[r];
                        end
                    end
                    flag_reg <= flag_reg | minfo.sat_any;
                end
                jmp_pkg::PH_WLD: begin
                    for (int r = 0; r < 3; r++) begin
                        world_reg[minfo.ctrl.col][r] <= msat[r];
                    end
                    flag_reg <= flag_reg | minfo.sat_any;
                end
                jmp_pkg::PH_SKN: begin
                    for (int r = 0; r < 4; r++) begin
                        sk_reg[minfo.ctrl.col][r] <= msat[r];
                    end
                    flag_reg <= flag_reg | minfo.sat_any;
                end
                default: ;
            endcase
        end
    end

    // Output channel: one column of the skin matrix per item.
    assign s_ready             = (state_reg == ST_IDLE);
    assign m_valid             = (state_reg == ST_OUT);
    assign m_skin_joint_number = skin_cnt_reg;
    assign m_column_index      = out_col_reg;
    assign m_elem_0            = sk_reg[out_col_reg][0];
    assign m_elem_1            = sk_reg[out_col_reg][1];
    assign m_elem_2            = sk_reg[out_col_reg][2];
    assign m_elem_3            = sk_reg[out_col_reg][3];
    assign m_last_column       = (out_col_reg == 2'd3);
    assign m_parent_error      = perr_reg;
    assign m_saturated         = flag_reg;

endmodule

`default_nettype wire

[src/jmp_checker.sv]
// Port-level checks of the joint matrix palette unit, bound to the top level.
`default_nettype none

module jmp_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [1:0]         m_column_index,
    input wire logic signed [31:0] m_elem_0,
    input wire logic               m_last_column
);

    // A stalled result item holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_elem_0)
                                && $stable(m_column_index))
        else $error("result item changed while stalled");

    // Reset leaves the block idle and empty.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

    // Columns of one matrix follow back to back in order.
    a_col_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_column |=>
            m_valid && (m_column_index == 2'($past(m_column_index) + 2'd1)))
        else $error("column sequence broken");

    // The last column flag marks column three only.
    a_last_col: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_column == (m_column_index == 2'd3)))
        else $error("last column flag wrong");

    // No new item is taken while results are pending.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted while results pending");

endmodule

bind joint_matrix_palette_unit jmp_checker u_jmp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_column_index(m_column_index),
    .m_elem_0      (m_elem_0),
    .m_last_column (m_last_column)
);

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the joint matrix palette unit.
`timescale 1ns / 100ps
`default_nettype none

module testbench;

    localparam int JOINT_LIMIT = 64;
    localparam int FRAC = 16;
    localparam longint UNIT = 64'sd1 << FRAC;
    localparam int STALL_LIMIT = 4000;

    // Opcodes the block ignores.
    localparam logic [2:0] OP_RSVD_5 = 3'd5;
    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;

    // One expected skin column, in the order the block sends them.
    typedef struct {
        logic [5:0]         joint_no;
        logic [1:0]         col;
        logic signed [31:0] e [4];
        logic               last;
        logic               perr;
        logic               sat;
    } skin_column_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_opcode = '0;
    logic signed [31:0] s_value_0 = '0, s_value_1 = '0, s_value_2 = '0;
    logic signed [31:0] s_value_3 = '0, s_value_4 = '0, s_value_5 = '0;
    logic [1:0] s_column_select = '0;
    logic signed [6:0] s_parent_index = '0;
    logic s_is_skin = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [5:0] m_skin_joint_number;
    logic [1:0] m_column_index;
    logic signed [31:0] m_elem_0, m_elem_1, m_elem_2, m_elem_3;
    logic m_last_column, m_parent_error, m_saturated;

    joint_matrix_palette_unit dut (.*);

    // Clock generator: 10 ns period.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // The predictor's own copy of the block state. The world store keeps
    // rows 0..2 of each joint, column-major, twelve words per joint.
    longint world_rows [JOINT_LIMIT*12];
    longint stage_trans [3];
    longint stage_quat [4];
    longint stage_scale [3];
    longint stage_inv_bind [16];
    int joints_done;
    int skins_done;

    skin_column_t pending_columns [$];
    int error_count = 0;
    int idle_cycles = 0;

    // Products are exact, then shifted with the sign kept (rounds down).
    function automatic longint fx_mul(longint a, longint b);
        return (a * b) >>> FRAC;
    endfunction

    function automatic longint clamp32(longint x, ref bit sat);
        if (x > 64'sd2147483647) begin
            sat = 1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            sat = 1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    // Column-major 4x4 product with per-element saturation.
    function automatic void mat_product(input longint a[16], input longint b[16],
                                        output longint o[16], ref bit sat);
        longint acc;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                acc = 0;
                for (int k = 0; k < 4; k++) acc += fx_mul(a[k*4+r], b[c*4+k]);
                o[c*4+r] = clamp32(acc, sat);
            end
        end
    endfunction

    task automatic reset_predictor();
        foreach (world_rows[i]) world_rows[i] = 0;
        foreach (stage_trans[i]) stage_trans[i] = 0;
        stage_quat = '{0, 0, 0, UNIT};
        foreach (stage_scale[i]) stage_scale[i] = UNIT;
        foreach (stage_inv_bind[i]) stage_inv_bind[i] = (i % 5 == 0) ? UNIT : 0;
        joints_done = 0;
        skins_done = 0;
    endtask

    // Commit of one joint: local T*R*S, world, and for a skin joint the
    // four skin columns queued as expectations.
    task automatic predict_commit(logic signed [6:0] parent, logic skin);
        longint qx, qy, qz, qw, xx, yy, zz, xy, xz, yz, wx, wy, wz;
        longint rot [9];
        longint local_m [16], parent_m [16], world_m [16], skin_m [16];
        bit sat;
        bit perr;
        longint p;
        skin_column_t col_item;
        sat = 0;
        qx = stage_quat[0]; qy = stage_quat[1]; qz = stage_quat[2]; qw = stage_quat[3];
        xx = fx_mul(qx, qx); yy = fx_mul(qy, qy); zz = fx_mul(qz, qz);
        xy = fx_mul(qx, qy); xz = fx_mul(qx, qz); yz = fx_mul(qy, qz);
        wx = fx_mul(qw, qx); wy = fx_mul(qw, qy); wz = fx_mul(qw, qz);
        rot[0] = UNIT - 2*(yy+zz); rot[1] = 2*(xy+wz); rot[2] = 2*(xz-wy);
        rot[3] = 2*(xy-wz); rot[4] = UNIT - 2*(xx+zz); rot[5] = 2*(yz+wx);
        rot[6] = 2*(xz+wy); rot[7] = 2*(yz-wx); rot[8] = UNIT - 2*(xx+yy);
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++)
                local_m[c*4+r] = clamp32(fx_mul(clamp32(rot[c*3+r], sat), stage_scale[c]), sat);
            local_m[c*4+3] = 0;
        end
        for (int r = 0; r < 3; r++) local_m[12+r] = stage_trans[r];
        local_m[15] = UNIT;

        p = parent;
        perr = (p >= 0) && (p >= joints_done);
        if (p < 0 || perr) begin
            world_m = local_m;
        end else begin
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 3; r++) parent_m[c*4+r] = world_rows[p*12+c*3+r];
                parent_m[c*4+3] = (c == 3) ? UNIT : 0;
            end
            mat_product(parent_m, local_m, world_m, sat);
        end
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 3; r++) world_rows[joints_done*12+c*3+r] = world_m[c*4+r];
        joints_done++;
        if (!skin) return;

        mat_product(world_m, stage_inv_bind, skin_m, sat);
        for (int c = 0; c < 4; c++) begin
            col_item.joint_no = skins_done[5:0];
            col_item.col = c[1:0];
            for (int r = 0; r < 4; r++) col_item.e[r] = skin_m[c*4+r][31:0];
            col_item.last = (c == 3);
            col_item.perr = perr;
            col_item.sat = sat;
            pending_columns.insert(pending_columns.size(), col_item);
        end
        skins_done++;
    endtask

    task automatic predict_item(logic [2:0] op, logic signed [31:0] v[6],
                                logic [1:0] csel, logic signed [6:0] parent, logic skin);
        case (op)
            jmp_pkg::OP_START: begin
                joints_done = 0;
                skins_done = 0;
            end
            jmp_pkg::OP_TS: begin
                for (int i = 0; i < 3; i++) begin
                    stage_trans[i] = v[i];
                    stage_scale[i] = v[3+i];
                end
            end
            jmp_pkg::OP_ROT: for (int i = 0; i < 4; i++) stage_quat[i] = v[i];
            jmp_pkg::OP_IB: for (int i = 0; i < 4; i++) stage_inv_bind[csel*4+i] = v[i];
            jmp_pkg::OP_COMMIT: if (joints_done < JOINT_LIMIT) predict_commit(parent, skin);
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Sends one item after a random gap and updates the predictor when the
    // block takes it. Valid stays high until the handshake completes; with
    // no gap the next item follows on the same valid.
    task automatic send_item(logic [2:0] op, logic signed [31:0] v[6],
                             logic [1:0] csel = 2'd0,
                             logic signed [6:0] parent = -7'sd1,
                             logic skin = 1'b0);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_value_0 <= v[0]; s_value_1 <= v[1]; s_value_2 <= v[2];
        s_value_3 <= v[3]; s_value_4 <= v[4]; s_value_5 <= v[5];
        s_column_select <= csel;
        s_parent_index <= parent;
        s_is_skin <= skin;
        do @(posedge aclk); while (!s_ready);
        predict_item(op, v, csel, parent, skin);
    endtask

    // Handy value helpers: small Q16.16 numbers and full-range noise.
    function automatic logic signed [31:0] near_value(int mag);
        return $signed($urandom_range(0, 2*mag)) - mag;
    endfunction

    function automatic logic signed [31:0] any_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom;
            default: return near_value(3 * 65536);
        endcase
    endfunction

    task automatic send_pose(int mag);
        logic signed [31:0] v[6];
        for (int i = 0; i < 6; i++) v[i] = near_value(mag);
        for (int i = 3; i < 6; i++) v[i] = 32'sd65536 + near_value(mag / 4);
        send_item(jmp_pkg::OP_TS, v);
        for (int i = 0; i < 6; i++) v[i] = near_value(65536);
        send_item(jmp_pkg::OP_ROT, v);
    endtask

    // Result side: random stalls on m_ready, compare against the oldest
    // expected column on each accepted item.
    initial begin
        int stall;
        skin_column_t want;
        logic signed [31:0] got [4];
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && aresetn));
            got = '{m_elem_0, m_elem_1, m_elem_2, m_elem_3};
            if (pending_columns.size() == 0) begin
                report_mismatch("unexpected skin column", 64'(m_column_index), -64'sd1);
            end else begin
                want = pending_columns.pop_front();
                if (m_skin_joint_number !== want.joint_no)
                    report_mismatch("skin_joint_number", 64'(m_skin_joint_number),
                                    64'(want.joint_no));
                if (m_column_index !== want.col)
                    report_mismatch("column_index", 64'(m_column_index), 64'(want.col));
                for (int r = 0; r < 4; r++)
                    if (got[r] !== want.e[r])
                        report_mismatch($sformatf("elem_%0d", r), 64'(got[r]),
                                        64'(want.e[r]));
                if (m_last_column !== want.last)
                    report_mismatch("last_column", 64'(m_last_column), 64'(want.last));
                if (m_parent_error !== want.perr)
                    report_mismatch("parent_error", 64'(m_parent_error), 64'(want.perr));
                if (m_saturated !== want.sat)
                    report_mismatch("saturated", 64'(m_saturated), 64'(want.sat));
            end
        end
    end

    // Watchdog: ends the run when no handshake happens for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT) begin
                $display("joint_matrix_palette_unit test failed");
                $finish;
            end
        end
    end

    // Drops valid and waits until every expected result has come.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_columns.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    // Identity staging, a root skin joint, a skin child of it, then a non-skin grandchild.
    task automatic test_identity_chain();
        logic signed [31:0] v[6];
        v = '{0, 0, 0, 0, 0, 0};
        send_item(jmp_pkg::OP_START, v);
        send_item(jmp_pkg::OP_COMMIT, v, 2'd0, -7'sd1, 1'b1);
        send_item(jmp_pkg::OP_COMMIT, v, 2'd0, 7'sd0, 1'b1);
        send_item(jmp_pkg::OP_COMMIT, v, 2'd0, 7'sd1, 1'b0);
    endtask

    // Field extremes: saturating scale, a huge quaternion and every
    // inverse-bind column, the parent-not-below-joint error and reserved opcodes.
    task automatic test_extremes();
        logic signed [31:0] v[6];
        v = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
        send_item(jmp_pkg::OP_TS, v);
        v = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0};
        send_item(jmp_pkg::OP_ROT, v);
        for (int c = 0; c < 4; c++) begin
            v = '{32'sh8000_0000, 32'sh7FFF_FFFF, -1, 1, 0, 0};
            send_item(jmp_pkg::OP_IB, v, c[1:0]);
        end
        send_item(jmp_pkg::OP_COMMIT, v, 2'd0, 7'sd63, 1'b1);
        send_item(jmp_pkg::OP_COMMIT, v, 2'd0, 7'sd3, 1'b1);
        send_item(jmp_pkg::OP_COMMIT, v, 2'd0, 7'sh40, 1'b1);
        send_item(OP_RSVD_5, v);
        send_item(OP_RSVD_6, v);
        send_item(OP_RSVD_7, v, 2'd3, 7'sd5, 1'b1);
    endtask

    // Fills the skeleton past its joint limit; the extra commits are dropped.
    task automatic test_joint_overflow();
        logic signed [31:0] v[6];
        v = '{0, 0, 0, 0, 0, 0};
        send_item(jmp_pkg::OP_START, v);
        for (int j = 0; j < JOINT_LIMIT + 3; j++)
            send_item(jmp_pkg::OP_COMMIT, v, 2'd0, 7'(j - 1),
                      (j % 9 == 0) || j >= JOINT_LIMIT - 1);
        wait_drained();
    endtask

    // Mostly well-formed skeletons with random poses, with noise mixed in.
    task automatic test_random_skeletons();
        logic signed [31:0] v[6];
        int joint_no;
        int sent;
        sent = 0;
        while (sent < 196) begin
            v = '{0, 0, 0, 0, 0, 0};
            send_item(jmp_pkg::OP_START, v);
            sent++;
            joint_no = 0;
            repeat ($urandom_range(1, 8)) begin
                if ($urandom_range(0, 9) == 0) begin
                    for (int i = 0; i < 6; i++) v[i] = any_value();
                    send_item(3'($urandom_range(0, 7)), v, 2'($urandom),
                              7'($urandom), 1'($urandom));
                    sent++;
                end else begin
                    send_pose(4 * 65536);
                    for (int i = 0; i < 4; i++) v[i] = near_value(2 * 65536);
                    send_item(jmp_pkg::OP_IB, v, 2'($urandom));
                    send_item(jmp_pkg::OP_COMMIT, v, 2'd0,
                              (joint_no == 0 || $urandom_range(0, 4) == 0) ? -7'sd1
                                  : 7'($urandom_range(0, joint_no - 1)),
                              $urandom_range(0, 3) != 0);
                    sent += 4;
                    joint_no++;
                end
            end
            // Once in a while let everything drain before the next skeleton.
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
    endtask

    initial begin
        reset_predictor();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_identity_chain();
        test_extremes();
        test_joint_overflow();
        test_random_skeletons();
        wait_drained();
        if (error_count == 0) begin
            $display("joint_matrix_palette_unit test passed");
        end else begin
            $display("joint_matrix_palette_unit test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
